/* src/pnbb_pkg.sv */
// shared types and constants for the packed nibble bitmap blitter
// no dependencies
`default_nettype none

package pnbb_pkg;

    localparam int COORD_BITS  = 12;
    localparam int POS_BITS    = 12;
    localparam int ORIGIN_BITS = 12;
    localparam int SIZE_BITS   = 13;
    localparam int COLOR_BITS  = 4;
    localparam int BYTE_BITS   = 8;
    localparam int INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS = SIZE_BITS;
    localparam int CNT_BITS =
        (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
    localparam logic [CNT_BITS-1:0] COORD_SPAN = CNT_BITS'(1) << COORD_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_BITS-1:0]   count_t;

    typedef enum logic [INDEX_BITS-1:0] {
        CFG_ORIGIN_X         = 3'd0,
        CFG_ORIGIN_Y         = 3'd1,
        CFG_BITMAP_WIDTH     = 3'd2,
        CFG_BITMAP_HEIGHT    = 3'd3,
        CFG_COLOR_KEY_ENABLE = 3'd4,
        CFG_REFRESH_AFTER    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [ORIGIN_BITS-1:0] origin_x;
        logic [ORIGIN_BITS-1:0] origin_y;
        logic [SIZE_BITS-1:0]   bitmap_width;
        logic [SIZE_BITS-1:0]   bitmap_height;
        logic                   color_key_enable;
        logic                   refresh_after;
    } cfg_t;

    typedef struct packed {
        logic [POS_BITS-1:0]   pixel_x;
        logic [POS_BITS-1:0]   pixel_y;
        logic [COLOR_BITS-1:0] color;
        logic                  write_enable;
        logic                  last_of_item;
        logic                  bitmap_done;
        logic                  refresh_request;
    } pixel_t;

    // zero acts as one, anything beyond the coordinate span acts as the span
    function automatic count_t clamp_size(input logic [SIZE_BITS-1:0] size);
        count_t wide;
        wide = CNT_BITS'(size);
        if (wide == '0)
            return CNT_BITS'(1);
        else if (wide > COORD_SPAN)
            return COORD_SPAN;
        else
            return wide;
    endfunction

endpackage

`default_nettype wire

/* src/pnbb_if.sv */
// valid/ready channel interfaces for bitmap bytes in and pixels out
// depends on pnbb_pkg
`default_nettype none

interface pnbb_byte_if;
    logic                               valid;
    logic                               ready;
    logic [pnbb_pkg::BYTE_BITS-1:0]     data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pnbb_pixel_if;
    logic                               valid;
    logic                               ready;
    logic [pnbb_pkg::POS_BITS-1:0]      pixel_x;
    logic [pnbb_pkg::POS_BITS-1:0]      pixel_y;
    logic [pnbb_pkg::COLOR_BITS-1:0]    color;
    logic                               write_enable;
    logic                               last_of_item;
    logic                               bitmap_done;
    logic                               refresh_request;

    modport source (
        output valid, output pixel_x, output pixel_y, output color,
        output write_enable, output last_of_item, output bitmap_done,
        output refresh_request, input ready
    );
    modport sink (
        input valid, input pixel_x, input pixel_y, input color,
        input write_enable, input last_of_item, input bitmap_done,
        input refresh_request, output ready
    );
endinterface

`default_nettype wire

/* src/pnbb_cfg_regs.sv */
// configuration register file of the bitmap blitter
// depends on pnbb_pkg
`default_nettype none

module pnbb_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [pnbb_pkg::INDEX_BITS-1:0]      cfg_index,
    input  wire logic [pnbb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output pnbb_pkg::cfg_t                            cfg
);

    pnbb_pkg::cfg_t cfg_reg;
    pnbb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (pnbb_pkg::cfg_index_t'(cfg_index))
                pnbb_pkg::CFG_ORIGIN_X:
                    cfg_next.origin_x = cfg_data[pnbb_pkg::ORIGIN_BITS-1:0];
                pnbb_pkg::CFG_ORIGIN_Y:
                    cfg_next.origin_y = cfg_data[pnbb_pkg::ORIGIN_BITS-1:0];
                pnbb_pkg::CFG_BITMAP_WIDTH:
                    cfg_next.bitmap_width = cfg_data[pnbb_pkg::SIZE_BITS-1:0];
                pnbb_pkg::CFG_BITMAP_HEIGHT:
                    cfg_next.bitmap_height = cfg_data[pnbb_pkg::SIZE_BITS-1:0];
                pnbb_pkg::CFG_COLOR_KEY_ENABLE:
                    cfg_next.color_key_enable = cfg_data[0];
                pnbb_pkg::CFG_REFRESH_AFTER:
                    cfg_next.refresh_after = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x         <= '0;
            cfg_reg.origin_y         <= '0;
            cfg_reg.bitmap_width     <= pnbb_pkg::SIZE_BITS'(1);
            cfg_reg.bitmap_height    <= pnbb_pkg::SIZE_BITS'(1);
            cfg_reg.color_key_enable <= 1'b0;
            cfg_reg.refresh_after    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/pnbb_raster.sv */
// raster position counters and per-pixel result logic
// depends on pnbb_pkg
`default_nettype none

module pnbb_raster (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pnbb_pkg::cfg_t                       cfg,
    input  wire logic                                 step,
    input  wire logic [pnbb_pkg::COLOR_BITS-1:0]      nibble,
    input  wire logic                                 last_in_byte,
    output pnbb_pkg::pixel_t                          pixel
);

    pnbb_pkg::coord_t column_reg;
    pnbb_pkg::coord_t column_next;
    pnbb_pkg::coord_t row_reg;
    pnbb_pkg::coord_t row_next;

    pnbb_pkg::count_t width_eff;
    pnbb_pkg::count_t height_eff;
    pnbb_pkg::count_t column_inc;
    pnbb_pkg::count_t row_inc;
    pnbb_pkg::coord_t sum_x;
    pnbb_pkg::coord_t sum_y;
    logic             row_end;
    logic             done;

    always_comb
    begin
        width_eff  = pnbb_pkg::clamp_size(cfg.bitmap_width);
        height_eff = pnbb_pkg::clamp_size(cfg.bitmap_height);
        column_inc = pnbb_pkg::CNT_BITS'(column_reg) + pnbb_pkg::CNT_BITS'(1);
        row_inc    = pnbb_pkg::CNT_BITS'(row_reg) + pnbb_pkg::CNT_BITS'(1);
        row_end    = column_inc >= width_eff;
        done       = row_end && (row_inc >= height_eff);
        sum_x      = pnbb_pkg::COORD_BITS'(cfg.origin_x) + column_reg;
        sum_y      = pnbb_pkg::COORD_BITS'(cfg.origin_y) + row_reg;

        pixel.pixel_x         = pnbb_pkg::POS_BITS'(sum_x);
        pixel.pixel_y         = pnbb_pkg::POS_BITS'(sum_y);
        pixel.color           = nibble;
        pixel.write_enable    = !(cfg.color_key_enable && (nibble == '0));
        pixel.last_of_item    = last_in_byte || done;
        pixel.bitmap_done     = done;
        pixel.refresh_request = done && cfg.refresh_after;
    end

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (step)
        begin
            priority if (done)
            begin
                column_next = '0;
                row_next    = '0;
            end
            else if (row_end)
            begin
                column_next = '0;
                row_next    = pnbb_pkg::COORD_BITS'(row_inc);
            end
            else
            begin
                column_next = pnbb_pkg::COORD_BITS'(column_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

/* src/packed_nibble_bitmap_blitter_unit.sv */
// an accepted byte passes through the byte holding register and then the pixel output register
// throughput: one pixel per cycle while the pixel output is not stalled, so a byte gives
//   two pixels, or one when its high nibble ends the bitmap; the byte holding register and
//   the pixel output register each take a new transfer while the other side is still busy
// reset: counters cleared, registers back to their defaults, both stages empty
// top level, depends on pnbb_pkg, pnbb_if, pnbb_cfg_regs, pnbb_raster
`default_nettype none

module packed_nibble_bitmap_blitter_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [pnbb_pkg::INDEX_BITS-1:0]      cfg_index,
    input  wire logic [pnbb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    pnbb_byte_if.sink                                 byte_in,
    pnbb_pixel_if.source                              pixel_out
);

    pnbb_pkg::cfg_t   cfg;
    pnbb_pkg::pixel_t pixel;

    logic                              hold_valid_reg;
    logic                              hold_valid_next;
    logic [pnbb_pkg::BYTE_BITS-1:0]    byte_reg;
    logic [pnbb_pkg::BYTE_BITS-1:0]    byte_next;
    logic                              phase_reg;
    logic                              phase_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    pnbb_pkg::pixel_t                  out_pixel_reg;
    pnbb_pkg::pixel_t                  out_pixel_next;

    logic                              out_free;
    logic                              fire;
    logic                              byte_finish;
    logic                              in_xfer;
    logic [pnbb_pkg::COLOR_BITS-1:0]   nibble;

    pnbb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pnbb_raster u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step         (fire),
        .nibble       (nibble),
        .last_in_byte (phase_reg),
        .pixel        (pixel)
    );

    always_comb
    begin
        nibble      = phase_reg ? byte_reg[pnbb_pkg::COLOR_BITS-1:0]
                                : byte_reg[pnbb_pkg::BYTE_BITS-1:pnbb_pkg::COLOR_BITS];
        out_free    = !out_valid_reg || pixel_out.ready;
        fire        = hold_valid_reg && out_free;
        byte_finish = fire && (phase_reg || pixel.bitmap_done);
        in_xfer     = byte_in.valid && byte_in.ready;
    end

    assign byte_in.ready = !hold_valid_reg || byte_finish;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        byte_next       = byte_reg;
        phase_next      = phase_reg;
        if (in_xfer)
        begin
            hold_valid_next = 1'b1;
            byte_next       = byte_in.data_byte;
            phase_next      = 1'b0;
        end
        else if (byte_finish)
        begin
            hold_valid_next = 1'b0;
            phase_next      = 1'b0;
        end
        else if (fire)
        begin
            phase_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pixel_next = out_pixel_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_pixel_next = pixel;
        end
        else if (pixel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        out_pixel_reg <= out_pixel_next;
    end

    assign pixel_out.valid           = out_valid_reg;
    assign pixel_out.pixel_x         = out_pixel_reg.pixel_x;
    assign pixel_out.pixel_y         = out_pixel_reg.pixel_y;
    assign pixel_out.color           = out_pixel_reg.color;
    assign pixel_out.write_enable    = out_pixel_reg.write_enable;
    assign pixel_out.last_of_item    = out_pixel_reg.last_of_item;
    assign pixel_out.bitmap_done     = out_pixel_reg.bitmap_done;
    assign pixel_out.refresh_request = out_pixel_reg.refresh_request;

endmodule

`default_nettype wire
